// ===== rtl/core/kce_pkg.sv =====
// Shared types, widths, register indexes and reset values of the Kirsch
// compass edge filter. No dependencies; every other file imports it.
package kce_pkg;

	localparam int PIX_W = 8;
	localparam int LW_W = 11;
	localparam int FH_W = 16;
	localparam int BIAS_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int SUM_W = 10;
	localparam int TOT_W = 11;
	localparam int RESP_W = 16;

	localparam int MAX_WIDTH_DEF = 1024;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS = 2'd2;

	localparam logic [LW_W-1:0] LINE_WIDTH_RST = 11'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;
	localparam logic [BIAS_W-1:0] BIAS_RST = 13'd0;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [7:0][PIX_W-1:0] ring_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [TOT_W-1:0] tot_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} lb_ctrl_t;

	typedef struct packed {
		logic valid;
		logic last;
	} kir_ctl_t;

	function automatic sum_t max_sum(sum_t a, sum_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ===== rtl/core/kce_if.sv =====
// Stream interfaces of the edge filter: pixel beats in, edge beats out.
// Depends on kce_pkg for the payload widths.
interface kce_pix_if import kce_pkg::*; ();
	logic valid;
	logic ready;
	pix_t pixel_value;
	logic frame_start;

	modport source(output valid, output pixel_value, output frame_start, input ready);
	modport sink(input valid, input pixel_value, input frame_start, output ready);
endinterface

interface kce_edge_if import kce_pkg::*; ();
	logic valid;
	logic ready;
	pix_t edge_value;
	logic frame_end;

	modport source(output valid, output edge_value, output frame_end, input ready);
	modport sink(input valid, input edge_value, input frame_end, output ready);
endinterface

// ===== rtl/core/kirsch_compass_edge_filter.sv =====
// Kirsch compass edge filter: one pixel beat per cycle in, one edge beat per
// interior pixel out; an interior pixel passes registers s1, s2, s3 and output.
// Throughput is one pixel per clock unless edges.ready stalls, set by the line
// stores and a three-stage compass pipeline behind the window stage.
// Asynchronous active-low reset clears counters, window and valid bits, loads
// the config reset values; line stores are not cleared and need no clearing pass.
// Uses kce_pkg, kce_if, kce_line_buf and kce_kirsch.
module kirsch_compass_edge_filter import kce_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	kce_pix_if.sink               pixels,
	kce_edge_if.source            edges
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int LW = ((CW > LW_W) ? CW : LW_W) + 1;

	logic [LW_W-1:0] line_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic [BIAS_W-1:0] bias_q;

	logic [CW-1:0] col_q;
	logic [FH_W-1:0] row_q;
	pix_t [5:0] win_q;

	logic valid_s1;
	pix_t pix_s1;
	logic [CW-1:0] col_s1;
	logic emit_s1;
	logic last_s1;

	logic [CW-1:0] col_cur;
	logic [FH_W-1:0] row_cur;
	logic [LW-1:0] lw_ext;
	logic [LW-1:0] w_eff;
	logic [FH_W-1:0] h_eff;
	logic last_col;
	logic last_row;
	logic accept;
	logic adv_s1;
	logic k_ready;
	pix_t top;
	pix_t mid;
	lb_ctrl_t lb_ctrl;
	kir_ctl_t k_ctl;
	ring_t ring;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			bias_q <= BIAS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_LINE_WIDTH: line_width_q <= cfg_data[LW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				REG_BIAS: bias_q <= cfg_data[BIAS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		col_cur = pixels.frame_start ? '0 : col_q;
		row_cur = pixels.frame_start ? '0 : row_q;
		lw_ext = LW'(line_width_q);
		if (lw_ext < LW'(3)) begin
			w_eff = LW'(3);
		end else if (lw_ext > LW'(MAX_WIDTH)) begin
			w_eff = LW'(MAX_WIDTH);
		end else begin
			w_eff = lw_ext;
		end
		h_eff = (frame_height_q < FH_W'(3)) ? FH_W'(3) : frame_height_q;
		last_col = LW'(col_cur) >= (w_eff - LW'(1));
		last_row = row_cur >= (h_eff - FH_W'(1));
	end

	assign adv_s1 = valid_s1 && (!emit_s1 || k_ready);
	assign pixels.ready = !valid_s1 || adv_s1;
	assign accept = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_cur + FH_W'(1);
				end else begin
					col_q <= col_cur + CW'(1);
					row_q <= row_cur;
				end
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pixels.pixel_value;
			col_s1 <= col_cur;
			emit_s1 <= (row_cur >= FH_W'(2)) && (col_cur >= CW'(2));
			last_s1 <= last_col && last_row;
		end
	end

	assign lb_ctrl.rd_en = accept;
	assign lb_ctrl.wr_en = adv_s1;

	kce_line_buf #(
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(lb_ctrl),
		.rd_addr(col_cur),
		.wr_addr(col_s1),
		.wr_upper(mid),
		.wr_lower(pix_s1),
		.rd_upper(top),
		.rd_lower(mid)
	);

	// Window holds columns c-2 and c-1 as top, middle, bottom.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (adv_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= pix_s1;
		end
	end

	// Ring runs clockwise from the top-left neighbor.
	always_comb begin
		ring[0] = win_q[0];
		ring[1] = win_q[3];
		ring[2] = top;
		ring[3] = mid;
		ring[4] = pix_s1;
		ring[5] = win_q[5];
		ring[6] = win_q[2];
		ring[7] = win_q[1];
	end

	assign k_ctl.valid = valid_s1 && emit_s1;
	assign k_ctl.last = last_s1;

	kce_kirsch u_kirsch (
		.clk(clk),
		.arst_n(arst_n),
		.bias(bias_q),
		.ctl(k_ctl),
		.ring(ring),
		.ready(k_ready),
		.edges(edges)
	);

endmodule

// ===== rtl/core/kce_line_buf.sv =====
// Two line stores (rows two above and one above) with registered reads and
// a bypass for a write and a read of the same column in one cycle. Uses kce_pkg.
module kce_line_buf import kce_pkg::*; #(
	parameter int DEPTH = MAX_WIDTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lb_ctrl_t      ctrl,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] wr_addr,
	input  pix_t          wr_upper,
	input  pix_t          wr_lower,
	output pix_t          rd_upper,
	output pix_t          rd_lower
);

	pix_t upper_mem [DEPTH];
	pix_t lower_mem [DEPTH];
	pix_t rd_upper_q;
	pix_t rd_lower_q;
	pix_t fwd_upper_q;
	pix_t fwd_lower_q;
	logic fwd_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			upper_mem[wr_addr] <= wr_upper;
			lower_mem[wr_addr] <= wr_lower;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_upper_q <= upper_mem[rd_addr];
			rd_lower_q <= lower_mem[rd_addr];
			fwd_upper_q <= wr_upper;
			fwd_lower_q <= wr_lower;
		end
	end

	// The memories return old data when a column is read in the cycle it is
	// written, so the value being written is kept and selected instead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (ctrl.rd_en) begin
			fwd_q <= ctrl.wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_upper = fwd_q ? fwd_upper_q : rd_upper_q;
	assign rd_lower = fwd_q ? fwd_lower_q : rd_lower_q;

endmodule

// ===== rtl/core/kce_kirsch.sv =====
// Three-stage compass arithmetic: ring sums, maximum, then scale, bias and
// clamp into the output register. Uses kce_pkg and kce_edge_if.
module kce_kirsch import kce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BIAS_W-1:0] bias,
	input  kir_ctl_t          ctl,
	input  ring_t             ring,
	output logic              ready,
	kce_edge_if.source        edges
);

	logic valid_s2;
	logic last_s2;
	sum_t [7:0] t_s2;
	tot_t total_s2;

	logic valid_s3;
	logic last_s3;
	sum_t best_s3;
	tot_t total_s3;

	logic out_valid_q;
	pix_t out_value_q;
	logic out_last_q;

	logic adv_s2;
	logic adv_s3;
	logic load_out;
	logic fire_in;

	sum_t [7:0] t_c;
	tot_t total_c;
	sum_t m01, m23, m45, m67, m03, m47, best_c;
	logic signed [RESP_W-1:0] resp;
	pix_t clamp_c;

	assign load_out = !out_valid_q || edges.ready;
	assign adv_s3 = valid_s3 && load_out;
	assign adv_s2 = valid_s2 && (!valid_s3 || adv_s3);
	assign ready = !valid_s2 || adv_s2;
	assign fire_in = ctl.valid && ready;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			t_c[k] = SUM_W'(ring[k]) + SUM_W'(ring[3'(k + 1)]) + SUM_W'(ring[3'(k + 2)]);
		end
		total_c = ((TOT_W'(ring[0]) + TOT_W'(ring[1])) + (TOT_W'(ring[2]) + TOT_W'(ring[3])))
			+ ((TOT_W'(ring[4]) + TOT_W'(ring[5])) + (TOT_W'(ring[6]) + TOT_W'(ring[7])));
	end

	always_comb begin
		m01 = max_sum(t_s2[0], t_s2[1]);
		m23 = max_sum(t_s2[2], t_s2[3]);
		m45 = max_sum(t_s2[4], t_s2[5]);
		m67 = max_sum(t_s2[6], t_s2[7]);
		m03 = max_sum(m01, m23);
		m47 = max_sum(m45, m67);
		best_c = max_sum(m03, m47);
	end

	// Five times the best triple less three times the rest is 8*best - 3*total.
	always_comb begin
		resp = $signed({3'b000, best_s3, 3'b000})
			- $signed({4'b0000, total_s3, 1'b0})
			- $signed({5'b00000, total_s3})
			+ $signed({{(RESP_W - BIAS_W){bias[BIAS_W-1]}}, bias});
		if (resp < 0) begin
			clamp_c = '0;
		end else if (resp > $signed(RESP_W'(255))) begin
			clamp_c = '1;
		end else begin
			clamp_c = resp[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_in) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s3 <= 1'b1;
			end else if (adv_s3) begin
				valid_s3 <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_in) begin
			t_s2 <= t_c;
			total_s2 <= total_c;
			last_s2 <= ctl.last;
		end
		if (adv_s2) begin
			best_s3 <= best_c;
			total_s3 <= total_s2;
			last_s3 <= last_s2;
		end
		if (adv_s3) begin
			out_value_q <= clamp_c;
			out_last_q <= last_s3;
		end
	end

	assign edges.valid = out_valid_q;
	assign edges.edge_value = out_value_q;
	assign edges.frame_end = out_last_q;

endmodule
